// File: rtl/core/rfb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfb_pkg: shared types, constants and tables of the radial band-pass core
// Register map, pipeline depths, exp lookup tables and output rounding.
// ----------------------------------------------------------------------------
package rfb_pkg;

	localparam int MAX_SIZE_DEF = 256;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RADIUS_LOW   = 3'd0,
		REG_RADIUS_HIGH  = 3'd1,
		REG_SMOOTH_WIDTH = 3'd2,
		REG_GAIN         = 3'd3,
		REG_SIZE_Y       = 3'd4,
		REG_SIZE_Z       = 3'd5
	} cfg_reg_t;

	// square root: 17 result bits, three per stage
	localparam int SQ_STEPS = 17;
	localparam int SQ_PER   = 3;
	localparam int SQ_ST    = (SQ_STEPS + SQ_PER - 1) / SQ_PER;

	// edge exponent t = d^2 * 256 / s^2, 12 quotient bits, three per stage
	localparam int DV_STEPS = 12;
	localparam int DV_PER   = 3;
	localparam int DV_ST    = (DV_STEPS + DV_PER - 1) / DV_PER;

	localparam int LANE_HI = 0;
	localparam int LANE_LO = 1;
	localparam int LANES   = 2;

	typedef struct packed {
		logic signed [31:0] re;
		logic signed [31:0] im;
	} cplx_t;

	typedef struct packed {
		logic hi;
		logic lo;
	} edge_t;

	// exp(-k), Q16
	function automatic logic [16:0] e_int(input logic [3:0] k);
		logic [16:0] r;
		unique case (k)
			4'd0:    r = 17'd65536;
			4'd1:    r = 17'd24109;
			4'd2:    r = 17'd8869;
			4'd3:    r = 17'd3263;
			4'd4:    r = 17'd1200;
			4'd5:    r = 17'd442;
			4'd6:    r = 17'd162;
			4'd7:    r = 17'd60;
			4'd8:    r = 17'd22;
			4'd9:    r = 17'd8;
			4'd10:   r = 17'd3;
			4'd11:   r = 17'd1;
			default: r = 17'd0;
		endcase
		return r;
	endfunction

	// exp(-k/16), Q16
	function automatic logic [16:0] e_hi(input logic [3:0] k);
		logic [16:0] r;
		unique case (k)
			4'd0:  r = 17'd65536;
			4'd1:  r = 17'd61565;
			4'd2:  r = 17'd57835;
			4'd3:  r = 17'd54331;
			4'd4:  r = 17'd51039;
			4'd5:  r = 17'd47947;
			4'd6:  r = 17'd45042;
			4'd7:  r = 17'd42313;
			4'd8:  r = 17'd39750;
			4'd9:  r = 17'd37341;
			4'd10: r = 17'd35079;
			4'd11: r = 17'd32954;
			4'd12: r = 17'd30957;
			4'd13: r = 17'd29081;
			4'd14: r = 17'd27319;
			4'd15: r = 17'd25664;
			default: r = 17'd0;
		endcase
		return r;
	endfunction

	// exp(-k/256), Q16
	function automatic logic [16:0] e_lo(input logic [3:0] k);
		logic [16:0] r;
		unique case (k)
			4'd0:  r = 17'd65536;
			4'd1:  r = 17'd65280;
			4'd2:  r = 17'd65026;
			4'd3:  r = 17'd64772;
			4'd4:  r = 17'd64520;
			4'd5:  r = 17'd64268;
			4'd6:  r = 17'd64018;
			4'd7:  r = 17'd63768;
			4'd8:  r = 17'd63520;
			4'd9:  r = 17'd63272;
			4'd10: r = 17'd63025;
			4'd11: r = 17'd62780;
			4'd12: r = 17'd62535;
			4'd13: r = 17'd62291;
			4'd14: r = 17'd62048;
			4'd15: r = 17'd61806;
			default: r = 17'd0;
		endcase
		return r;
	endfunction

	function automatic logic [31:0] mag32(input logic signed [31:0] v);
		return v[31] ? (~v + 32'd1) : v;
	endfunction

	// round |v|*g back to Q16.16, restore sign, clamp to int32; bit 32 flags a clamp
	function automatic logic [32:0] round_sat(input logic [63:0] prod, input logic neg);
		logic [63:0] r;
		logic [47:0] p;
		logic [32:0] res;
		r = prod + 64'd32768;
		p = r[63:16];
		if (neg) begin
			if (p > 48'h0000_8000_0000) res = {1'b1, 32'h8000_0000};
			else                        res = {1'b0, 32'(48'd0 - p)};
		end else begin
			if (p > 48'h0000_7FFF_FFFF) res = {1'b1, 32'h7FFF_FFFF};
			else                        res = {1'b0, p[31:0]};
		end
		return res;
	endfunction

endpackage

// File: rtl/core/radial_fourier_bandpass_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radial_fourier_bandpass_core: Gaussian-edge radial band-pass for 3D spectra
// Folds y/z to frequency, takes the Q8.8 radius and scales coefficients
// outside [radius_low, radius_high] by exp(-(d/smooth)^2) * gain, saturated.
// ----------------------------------------------------------------------------
// Pipeline: 6 square root stages, 4 divide stages.
// Throughput: one item per cycle, every cycle; busy stays low.
// The receiver cannot stall; each result shows for one cycle with done.
// Reset clears the pipeline valid bits and loads the register defaults.
module radial_fourier_bandpass_core
	import rfb_pkg::*;
#(
	parameter int MAX_SIZE = MAX_SIZE_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic signed [31:0]    real_in,
	input  logic signed [31:0]    imag_in,
	input  logic [7:0]            x_index,
	input  logic [7:0]            y_index,
	input  logic [7:0]            z_index,
	output logic                  done,
	output logic signed [31:0]    real_out,
	output logic signed [31:0]    imag_out,
	output logic                  saturated
);

	localparam int NW    = $clog2(MAX_SIZE + 1);
	localparam int CW    = (NW > 9) ? NW : 9;
	localparam int ST_E  = 3 + SQ_ST;
	localparam int ST_DQ = ST_E + 1;
	localparam int ST_F1 = ST_DQ + DV_ST + 1;
	localparam int ST_G  = ST_F1 + 2;
	localparam int LAT   = ST_G + 4;
	localparam int AP_N  = ST_G + 4 - ST_E;

	// ---------------- configuration ----------------
	logic [15:0] radius_low_q, radius_high_q, smooth_width_q;
	logic [31:0] gain_q, s2_q;
	logic [8:0]  size_y_q, size_z_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_low_q   <= 16'd0;
			radius_high_q  <= 16'hFFFF;
			smooth_width_q <= 16'd0;
			gain_q         <= 32'd65536;
			size_y_q       <= 9'd256;
			size_z_q       <= 9'd256;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_RADIUS_LOW:   radius_low_q   <= cfg_wdata[15:0];
				REG_RADIUS_HIGH:  radius_high_q  <= cfg_wdata[15:0];
				REG_SMOOTH_WIDTH: smooth_width_q <= cfg_wdata[15:0];
				REG_GAIN:         gain_q         <= cfg_wdata;
				REG_SIZE_Y:       size_y_q       <= cfg_wdata[8:0];
				REG_SIZE_Z:       size_z_q       <= cfg_wdata[8:0];
				default: ;
			endcase
		end
	end

	// smooth^2 settles in the cycle after smooth_width_q, long before an item needs it
	always_ff @(posedge clk) begin
		s2_q <= 32'(smooth_width_q * smooth_width_q);
	end

	// ---------------- handshake and valid line ----------------
	logic           acc;
	logic [LAT-1:0] vld_q;

	assign busy = 1'b0;
	assign acc  = start & ~busy;
	assign done = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else         vld_q <= {vld_q[LAT-2:0], acc};
	end

	// ---------------- stage 1: fold y/z ----------------
	function automatic logic [7:0] fold_idx(input logic [7:0] idx, input logic [8:0] sz);
		logic [CW-1:0] n;
		logic [CW-1:0] i;
		n = CW'(sz);
		if (n < CW'(2))             n = CW'(2);
		else if (n > CW'(MAX_SIZE)) n = CW'(MAX_SIZE);
		i = CW'(idx);
		if (i <= (n >> 1)) return idx;
		if (n >= i)        return 8'(n - i);
		return 8'(i - n);
	endfunction

	logic [7:0]  x_s1, fy_s1, fz_s1;
	logic [17:0] sum_s2;
	cplx_t       cplx_q [ST_G];

	always_ff @(posedge clk) begin
		x_s1      <= x_index;
		fy_s1     <= fold_idx(y_index, size_y_q);
		fz_s1     <= fold_idx(z_index, size_z_q);
		cplx_q[0] <= '{re: real_in, im: imag_in};
		for (int k = 1; k < ST_G; k++) cplx_q[k] <= cplx_q[k-1];
		// stage 2: radius squared
		sum_s2 <= 18'(x_s1 * x_s1) + 18'(fy_s1 * fy_s1) + 18'(fz_s1 * fz_s1);
	end

	// ---------------- square root of sum << 16, digit by digit ----------------
	logic [20:0] sq_rem_q  [SQ_ST];
	logic [16:0] sq_root_q [SQ_ST];
	logic [17:0] sq_sum_q  [SQ_ST];

	for (genvar j = 0; j < SQ_ST; j++) begin : g_sq
		logic [20:0] rem_in, rem_nx;
		logic [16:0] root_in, root_nx;
		logic [17:0] sum_in;

		if (j == 0) begin : g_first
			assign rem_in  = '0;
			assign root_in = '0;
			assign sum_in  = sum_s2;
		end else begin : g_next
			assign rem_in  = sq_rem_q[j-1];
			assign root_in = sq_root_q[j-1];
			assign sum_in  = sq_sum_q[j-1];
		end

		always_comb begin
			logic [33:0] v;
			logic [20:0] r4, t;
			v       = {sum_in, 16'd0};
			rem_nx  = rem_in;
			root_nx = root_in;
			r4      = '0;
			t       = '0;
			for (int p = 0; p < SQ_PER; p++) begin
				if (j * SQ_PER + p < SQ_STEPS) begin
					r4 = {rem_nx[18:0], v[33 - 2 * (j * SQ_PER + p) -: 2]};
					t  = {2'b00, root_nx, 2'b01};
					if (r4 >= t) begin
						rem_nx  = r4 - t;
						root_nx = {root_nx[15:0], 1'b1};
					end else begin
						rem_nx  = r4;
						root_nx = {root_nx[15:0], 1'b0};
					end
				end
			end
		end

		always_ff @(posedge clk) begin
			sq_rem_q[j]  <= rem_nx;
			sq_root_q[j] <= root_nx;
			sq_sum_q[j]  <= sum_in;
		end
	end

	// ---------------- edge test and distance past the edge ----------------
	logic [16:0] rad;
	logic [16:0] d_s9 [LANES];
	logic [33:0] dsq_s10 [LANES];
	edge_t       ap_q [AP_N];

	assign rad = sq_root_q[SQ_ST-1];

	always_ff @(posedge clk) begin
		ap_q[0]       <= '{hi: rad > {1'b0, radius_high_q}, lo: rad < {1'b0, radius_low_q}};
		for (int k = 1; k < AP_N; k++) ap_q[k] <= ap_q[k-1];
		d_s9[LANE_HI] <= rad - {1'b0, radius_high_q};
		d_s9[LANE_LO] <= {1'b0, radius_low_q - rad[15:0]};
		for (int l = 0; l < LANES; l++) dsq_s10[l] <= 34'(d_s9[l] * d_s9[l]);
	end

	// ---------------- t = d^2 * 256 / s^2, restoring divide ----------------
	logic [41:0] dv_rem_q [LANES][DV_ST];
	logic [11:0] dv_quo_q [LANES][DV_ST];
	logic        dv_ovf_q [LANES][DV_ST];

	for (genvar l = 0; l < LANES; l++) begin : g_lane
		for (genvar j = 0; j < DV_ST; j++) begin : g_dv
			logic [41:0] rem_in, rem_nx;
			logic [11:0] quo_in, quo_nx;
			logic        ovf_in;

			if (j == 0) begin : g_first
				assign rem_in = {dsq_s10[l], 8'd0};
				assign quo_in = '0;
				// quotient would need more than 12 bits
				assign ovf_in = {2'b00, dsq_s10[l]} >= {s2_q, 4'd0};
			end else begin : g_next
				assign rem_in = dv_rem_q[l][j-1];
				assign quo_in = dv_quo_q[l][j-1];
				assign ovf_in = dv_ovf_q[l][j-1];
			end

			always_comb begin
				logic [43:0] sub;
				int          b;
				rem_nx = rem_in;
				quo_nx = quo_in;
				sub    = '0;
				for (int p = 0; p < DV_PER; p++) begin
					b = DV_STEPS - 1 - (j * DV_PER + p);
					if (b >= 0) begin
						sub = 44'(s2_q) << b;
						if ({2'b00, rem_nx} >= sub) begin
							rem_nx    = 42'({2'b00, rem_nx} - sub);
							quo_nx[b] = 1'b1;
						end
					end
				end
			end

			always_ff @(posedge clk) begin
				dv_rem_q[l][j] <= rem_nx;
				dv_quo_q[l][j] <= quo_nx;
				dv_ovf_q[l][j] <= ovf_in;
			end
		end
	end

	// ---------------- edge factor and gain ----------------
	logic [16:0] f1_s15 [LANES];
	logic [3:0]  tlo_s15 [LANES];
	logic        zero_s15 [LANES];
	logic [15:0] f_s16 [LANES];
	logic [31:0] g_s17 [LANES];

	for (genvar l = 0; l < LANES; l++) begin : g_fac
		logic [11:0] t;
		logic [34:0] m1, m2;
		logic [48:0] m3;

		assign t  = dv_quo_q[l][DV_ST-1];
		assign m1 = 35'(e_int(t[11:8]) * e_hi(t[7:4])) + 35'd32768;
		assign m2 = 35'(f1_s15[l] * e_lo(tlo_s15[l])) + 35'd32768;
		assign m3 = 49'(f_s16[l] * gain_q) + 49'd32768;

		always_ff @(posedge clk) begin
			f1_s15[l]   <= m1[32:16];
			tlo_s15[l]  <= t[3:0];
			// t of 12.0 or more gives a zero factor
			zero_s15[l] <= dv_ovf_q[l][DV_ST-1] | (t[11:10] == 2'b11);
			if (zero_s15[l])           f_s16[l] <= 16'd0;
			else if (m2[32:16] > 17'd65535) f_s16[l] <= 16'hFFFF;
			else                       f_s16[l] <= m2[31:16];
			g_s17[l]    <= m3[47:16];
		end
	end

	// ---------------- upper edge scaling ----------------
	logic        hard_cut;
	logic [63:0] prod_re_s18, prod_im_s18;
	logic        neg_re_s18, neg_im_s18;
	cplx_t       pass_s18;
	logic [31:0] glo_s18, glo_s19;
	logic [32:0] rs_re_h, rs_im_h;
	cplx_t       v_s19;
	logic        sat_s19;

	assign hard_cut = (smooth_width_q == 16'd0);
	assign rs_re_h  = round_sat(prod_re_s18, neg_re_s18);
	assign rs_im_h  = round_sat(prod_im_s18, neg_im_s18);

	always_ff @(posedge clk) begin
		prod_re_s18 <= 64'(mag32(cplx_q[ST_G-1].re) * g_s17[LANE_HI]);
		prod_im_s18 <= 64'(mag32(cplx_q[ST_G-1].im) * g_s17[LANE_HI]);
		neg_re_s18  <= cplx_q[ST_G-1].re[31];
		neg_im_s18  <= cplx_q[ST_G-1].im[31];
		pass_s18    <= cplx_q[ST_G-1];
		glo_s18     <= g_s17[LANE_LO];
		glo_s19     <= glo_s18;

		if (!ap_q[ST_G+1-ST_E].hi) begin
			v_s19   <= pass_s18;
			sat_s19 <= 1'b0;
		end else if (hard_cut) begin
			v_s19   <= '0;
			sat_s19 <= 1'b0;
		end else begin
			v_s19   <= '{re: rs_re_h[31:0], im: rs_im_h[31:0]};
			sat_s19 <= rs_re_h[32] | rs_im_h[32];
		end
	end

	// ---------------- lower edge scaling, applied after the upper one ----------------
	logic [63:0] prod_re_s20, prod_im_s20;
	logic        neg_re_s20, neg_im_s20;
	cplx_t       pass_s20;
	logic        sat_s20;
	logic [32:0] rs_re_l, rs_im_l;

	assign rs_re_l = round_sat(prod_re_s20, neg_re_s20);
	assign rs_im_l = round_sat(prod_im_s20, neg_im_s20);

	always_ff @(posedge clk) begin
		prod_re_s20 <= 64'(mag32(v_s19.re) * glo_s19);
		prod_im_s20 <= 64'(mag32(v_s19.im) * glo_s19);
		neg_re_s20  <= v_s19.re[31];
		neg_im_s20  <= v_s19.im[31];
		pass_s20    <= v_s19;
		sat_s20     <= sat_s19;

		if (!ap_q[ST_G+3-ST_E].lo) begin
			real_out  <= pass_s20.re;
			imag_out  <= pass_s20.im;
			saturated <= sat_s20;
		end else if (hard_cut) begin
			real_out  <= '0;
			imag_out  <= '0;
			saturated <= sat_s20;
		end else begin
			real_out  <= rs_re_l[31:0];
			imag_out  <= rs_im_l[31:0];
			saturated <= sat_s20 | rs_re_l[32] | rs_im_l[32];
		end
	end

`ifndef SYNTHESIS
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[0] |-> ##(LAT-1) done)
		else $error("item did not reach the output after the pipeline latency");

	a_result_known: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !$isunknown({real_out, imag_out, saturated}))
		else $error("result fields unknown while done is high");
`endif

endmodule
